FILE: rtl/rau_pkg.sv
`default_nettype none

package rau_pkg;

  // field widths of the request and result items
  localparam int OPC_W   = 2;
  localparam int OPD_W   = 16;
  localparam int NUMER_W = 33;
  localparam int DENOM_W = 32;

  // default operand width
  localparam int WIDTH_DEF = 16;

  // opcodes
  localparam logic [OPC_W-1:0] OP_ADD  = 2'd0;
  localparam logic [OPC_W-1:0] OP_LESS = 2'd1;
  localparam logic [OPC_W-1:0] OP_RED  = 2'd2;
  localparam logic [OPC_W-1:0] OP_RDBL = 2'd3;

endpackage

`default_nettype wire

FILE: rtl/rau_in_if.sv
`default_nettype none

interface rau_in_if import rau_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OPC_W-1:0] opcode;
  logic [OPD_W-1:0] x_numer;
  logic [OPD_W-1:0] x_denom;
  logic [OPD_W-1:0] y_numer;
  logic [OPD_W-1:0] y_denom;

  modport source (output valid, opcode, x_numer, x_denom, y_numer, y_denom, input ready);
  modport sink (input valid, opcode, x_numer, x_denom, y_numer, y_denom, output ready);
endinterface

`default_nettype wire

FILE: rtl/rau_out_if.sv
`default_nettype none

interface rau_out_if import rau_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [NUMER_W-1:0] res_numer;
  logic [DENOM_W-1:0] res_denom;
  logic               flag;

  modport source (output valid, res_numer, res_denom, flag, input ready);
  modport sink (input valid, res_numer, res_denom, flag, output ready);
endinterface

`default_nettype wire

FILE: rtl/rational_arithmetic_unit_core.sv
// divider: OW = min(WIDTH, 16), one quotient bit per cycle
// reducible: k passes, k the number of remainder steps of the gcd loop, then the output state
// reduce: k+2 passes, then the output state; add and less than: k+2 passes, then S_M1 to S_M3
// and the output state; one request at a time, ready only while idle; k is at most 23 at 16 bits
// reset: synchronous active-low rst_n clears the sequencer and the result valid
`default_nettype none

module rational_arithmetic_unit_core import rau_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rau_in_if.sink    in_req,
  rau_out_if.source out_res
);

  localparam int OW = (WIDTH < OPD_W) ? WIDTH : OPD_W;
  localparam int PW = 2 * OW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_Q1   = 3'd2;
  localparam logic [2:0] S_Q2   = 3'd3;
  localparam logic [2:0] S_M1   = 3'd4;
  localparam logic [2:0] S_M2   = 3'd5;
  localparam logic [2:0] S_M3   = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]         state_r, state_nxt;
  logic               start_r, start_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OPC_W-1:0]   op_r;
  logic [OW-1:0]      xn_r, xd_r, yn_r, yd_r;
  logic [OW-1:0]      a_r, b_r, g_r, q1_r, q2_r;
  logic [PW-1:0]      prod_r, l_r, sx_r;
  logic [NUMER_W-1:0] out_numer_r;
  logic [DENOM_W-1:0] out_denom_r;
  logic               out_flag_r;

  logic               acc;
  logic               in_frac;
  logic               frac;
  logic [OW-1:0]      xn_in, xd_in, yn_in, yd_in;
  logic [OW-1:0]      xd_c, yd_c;
  logic               div_done;
  logic [OW-1:0]      div_quot, div_rem;
  logic [OW-1:0]      mul_a, mul_b;
  logic [PW-1:0]      mul_p;
  logic [PW:0]        sum;
  logic               out_free;
  logic               out_load;
  logic [NUMER_W-1:0] numer_mux;
  logic [DENOM_W-1:0] denom_mux;
  logic               flag_mux;

  // request decode, zero denominators clamp to one
  always_comb begin
    acc     = in_req.valid && in_req.ready;
    xn_in   = in_req.x_numer[OW-1:0];
    xd_in   = in_req.x_denom[OW-1:0];
    yn_in   = in_req.y_numer[OW-1:0];
    yd_in   = in_req.y_denom[OW-1:0];
    xd_c    = (xd_in == '0) ? OW'(1) : xd_in;
    yd_c    = (yd_in == '0) ? OW'(1) : yd_in;
    in_frac = (in_req.opcode == OP_ADD) || (in_req.opcode == OP_LESS);
    frac    = (op_r == OP_ADD) || (op_r == OP_LESS);
  end

  assign in_req.ready = (state_r == S_IDLE);

  // shared divider for the gcd loop and the divisions by the gcd
  rau_div #(.W(OW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (a_r),
    .divisor  (b_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // shared multiplier operand select
  always_comb begin
    unique case (state_r)
      S_M1: begin
        mul_a = q1_r;
        mul_b = yd_r;
      end
      S_M2: begin
        mul_a = xn_r;
        mul_b = q2_r;
      end
      default: begin
        mul_a = yn_r;
        mul_b = q1_r;
      end
    endcase
    mul_p = PW'(mul_a) * PW'(mul_b);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    start_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          state_nxt = S_GCD;
          start_nxt = 1'b1;
        end
      end
      S_GCD: begin
        if (div_done) begin
          if (div_rem == '0) begin
            state_nxt = (op_r == OP_RDBL) ? S_OUT : S_Q1;
            start_nxt = (op_r != OP_RDBL);
          end else begin
            start_nxt = 1'b1;
          end
        end
      end
      S_Q1: begin
        if (div_done) begin
          state_nxt = S_Q2;
          start_nxt = 1'b1;
        end
      end
      S_Q2: begin
        if (div_done) begin
          state_nxt = frac ? S_M1 : S_OUT;
        end
      end
      S_M1: state_nxt = S_M2;
      S_M2: state_nxt = S_M3;
      S_M3: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register handshake
  always_comb begin
    out_free      = !out_valid_r || out_res.ready;
    out_load      = (state_r == S_OUT) && out_free;
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_res.ready);
  end

  // result select per opcode
  always_comb begin
    sum = {1'b0, sx_r} + {1'b0, prod_r};
    unique case (op_r)
      OP_ADD: begin
        numer_mux = NUMER_W'(sum);
        denom_mux = DENOM_W'(l_r);
        flag_mux  = 1'b0;
      end
      OP_LESS: begin
        numer_mux = '0;
        denom_mux = DENOM_W'(1);
        flag_mux  = (sx_r < prod_r);
      end
      OP_RED: begin
        numer_mux = NUMER_W'(q1_r);
        denom_mux = DENOM_W'(q2_r);
        flag_mux  = 1'b0;
      end
      default: begin
        numer_mux = '0;
        denom_mux = DENOM_W'(1);
        flag_mux  = (g_r > OW'(1));
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          op_r <= in_req.opcode;
          xn_r <= xn_in;
          xd_r <= xd_c;
          yn_r <= yn_in;
          yd_r <= yd_c;
          a_r  <= in_frac ? xd_c : xn_in;
          b_r  <= in_frac ? yd_c : xd_c;
        end
      end
      S_GCD: begin
        if (div_done) begin
          if (div_rem == '0) begin
            g_r <= b_r;
            a_r <= frac ? xd_r : xn_r;
          end else begin
            a_r <= b_r;
            b_r <= div_rem;
          end
        end
      end
      S_Q1: begin
        if (div_done) begin
          q1_r <= div_quot;
          a_r  <= frac ? yd_r : xd_r;
        end
      end
      S_Q2: begin
        if (div_done) begin
          q2_r <= div_quot;
        end
      end
      S_M1: prod_r <= mul_p;
      S_M2: begin
        l_r    <= prod_r;
        prod_r <= mul_p;
      end
      S_M3: begin
        sx_r   <= prod_r;
        prod_r <= mul_p;
      end
      default: begin
        if (out_load) begin
          out_numer_r <= numer_mux;
          out_denom_r <= denom_mux;
          out_flag_r  <= flag_mux;
        end
      end
    endcase
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.res_numer = out_numer_r;
  assign out_res.res_denom = out_denom_r;
  assign out_res.flag      = out_flag_r;

  // the divider never starts a pass with a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> (b_r != '0))
    else $error("divider started with zero divisor");

  // divider completions only land in the division states
  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_GCD || state_r == S_Q1 || state_r == S_Q2))
    else $error("divider done outside a division state");

  // leaving the output state always presents a result
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_res.valid)
    else $error("result not presented after load");

  // no divider start directly follows another
  a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |=> !start_r)
    else $error("back to back divider starts");

endmodule

`default_nettype wire

FILE: rtl/rau_div.sv
`default_nettype none

module rau_div import rau_pkg::*; #(
  parameter int W = WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quot,
  output logic [W-1:0]      rem
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  dvs_r;

  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          take;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, quo_r[W-1]};
    diff  = trial - {1'b0, dvs_r};
    take  = (trial >= {1'b0, dvs_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
      cnt_r <= CW'(W - 1);
    end else if (busy_r) begin
      rem_r <= take ? diff[W-1:0] : trial[W-1:0];
      quo_r <= {quo_r[W-2:0], take};
      cnt_r <= cnt_r - CW'(1);
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

  // a pass completes only after the unit has been working
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a pass in progress");

endmodule

`default_nettype wire
